### design/graph_max_cut_gray_search_macros.svh
// Assertion macros for the graph max-cut search block.
// Used by the port checker; no other dependencies.
`ifndef GRAPH_MAX_CUT_GRAY_SEARCH_MACROS_SVH
`define GRAPH_MAX_CUT_GRAY_SEARCH_MACROS_SVH

// same-cycle implication
`define GMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("graph_max_cut_gray_search: port check failed");

// next-cycle implication
`define GMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("graph_max_cut_gray_search: port check failed");

`endif

### design/gmc_pkg.sv
// Shared types, widths and helpers for the graph max-cut search block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gmc_pkg;

    localparam int MAX_V   = 16;
    localparam int ROW_W   = 15;
    localparam int IDX_W   = 4;
    localparam int OUT_W   = 7;
    localparam int CNT_W   = 5;
    localparam int DELTA_W = 6;
    localparam int CUT_W   = 8;

    typedef enum logic [1:0] {
        FUNC_ROW    = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_RUN    = 2'd2
    } t_func;

    function automatic logic [CNT_W-1:0] popcount(input logic [MAX_V-1:0] x);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < MAX_V; b++) begin
            n = n + CNT_W'(x[b]);
        end
        return n;
    endfunction

endpackage

### design/gmc_build_unit.sv
// Edge extraction for one list position of the induced subgraph.
// Depends on gmc_pkg for widths and popcount.
`timescale 1ns / 1ps

module gmc_build_unit #(
    parameter int VERTICES = 15
) (
    input  logic [gmc_pkg::ROW_W-1:0]           i_row,
    input  logic [gmc_pkg::IDX_W-1:0]           i_av [VERTICES],
    input  logic [$clog2(VERTICES)-1:0]         i_pos,
    input  logic [$clog2(VERTICES+1)-1:0]       i_count,
    output logic [VERTICES-1:0]                 o_hit,
    output logic [gmc_pkg::CNT_W-1:0]           o_hit_cnt
);

    localparam int PW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);

    logic [gmc_pkg::ROW_W:0] row_ext;

    assign row_ext = {1'b0, i_row};

    always_comb begin
        for (int j = 0; j < VERTICES; j++) begin
            o_hit[j] = (PW'(j) > i_pos) && (CW'(j) < i_count) && row_ext[i_av[j]];
        end
    end

    assign o_hit_cnt = gmc_pkg::popcount(gmc_pkg::MAX_V'(o_hit));

endmodule

### design/gmc_delta_unit.sv
// Gray-code step unit: picks the flipped vertex and computes the cut change.
// Depends on gmc_pkg for widths and popcount.
`timescale 1ns / 1ps

module gmc_delta_unit #(
    parameter int VERTICES = 15
) (
    input  logic [VERTICES-1:0]                 i_subset,
    input  logic [VERTICES-1:0]                 i_side,
    input  logic [VERTICES-1:0]                 i_full,
    input  logic [VERTICES-1:0]                 i_nb,
    output logic [$clog2(VERTICES)-1:0]         o_pos,
    output logic signed [gmc_pkg::DELTA_W-1:0]  o_delta
);

    localparam int PW = $clog2(VERTICES);

    logic [VERTICES-1:0]        same;
    logic [gmc_pkg::CNT_W-1:0]  pos_cnt;
    logic [gmc_pkg::CNT_W-1:0]  neg_cnt;

    always_comb begin
        o_pos = '0;
        for (int b = VERTICES - 1; b >= 0; b--) begin
            if (i_subset[b]) begin
                o_pos = PW'(b);
            end
        end
    end

    assign same    = i_side[o_pos] ? i_side : (~i_side & i_full);
    assign pos_cnt = gmc_pkg::popcount(gmc_pkg::MAX_V'(i_nb & same));
    assign neg_cnt = gmc_pkg::popcount(gmc_pkg::MAX_V'(i_nb & ~same & i_full));
    assign o_delta = $signed({1'b0, pos_cnt}) - $signed({1'b0, neg_cnt});

endmodule

### design/graph_max_cut_gray_search.sv
// Top level of the exhaustive max-cut search: storage, sequencer, accumulator.
// Depends on gmc_pkg, gmc_build_unit and gmc_delta_unit.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a rising edge with
//   start high and busy low. i_func selects a row write (FUNC_ROW), a vertex
//   append (FUNC_APPEND) or a search run (FUNC_RUN); code 3 is dropped.
//   Row writes and appends leave busy low, so they can be issued on every
//   cycle.
//   A run with k listed vertices holds busy high through edge extraction of
//   the k list positions (one list position per cycle), 2^k - 1 Gray-code
//   steps through the shared delta unit (one bipartition per cycle), and a
//   drain state that retires the last step. The result appears on o_max_cut,
//   o_edge_count and o_deficiency with o_valid high for exactly one cycle, the
//   cycle in which busy returns low; an empty list goes straight to the drain
//   state. A run empties the active list.
//   The receiver cannot stall: each result is shown for one cycle only.
//   Reset (i_rst_n low, synchronous) clears all adjacency rows, the active
//   list, the sequencer and o_valid.
`timescale 1ns / 1ps

module graph_max_cut_gray_search #(
    parameter int VERTICES = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic [gmc_pkg::IDX_W-1:0]       i_vertex_index,
    input  logic [gmc_pkg::ROW_W-1:0]       i_row_bits,
    output logic                            o_valid,
    output logic [gmc_pkg::OUT_W-1:0]       o_max_cut,
    output logic [gmc_pkg::OUT_W-1:0]       o_edge_count,
    output logic [gmc_pkg::OUT_W-1:0]       o_deficiency
);

    localparam int PW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);
    localparam int IW = $clog2(VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SEARCH,
        ST_DRAIN
    } t_state;

    t_state                                 r_state;
    logic [gmc_pkg::ROW_W-1:0]              r_adj [VERTICES];
    logic [gmc_pkg::IDX_W-1:0]              r_av [VERTICES];
    logic [VERTICES-1:0]                    r_local [VERTICES];
    logic [CW-1:0]                          r_count;
    logic [PW-1:0]                          r_pos;
    logic [VERTICES-1:0]                    r_subset;
    logic [VERTICES-1:0]                    r_side;
    logic [VERTICES-1:0]                    r_full;
    logic signed [gmc_pkg::CUT_W-1:0]       r_cut;
    logic [gmc_pkg::OUT_W-1:0]              r_best;
    logic [gmc_pkg::OUT_W-1:0]              r_edges;
    logic signed [gmc_pkg::DELTA_W-1:0]     r_delta;
    logic                                   r_dvalid;
    logic                                   r_valid;
    logic [gmc_pkg::OUT_W-1:0]              r_max_cut;
    logic [gmc_pkg::OUT_W-1:0]              r_edge_count;
    logic [gmc_pkg::OUT_W-1:0]              r_deficiency;

    logic signed [gmc_pkg::CUT_W-1:0]       n_cut;
    logic [gmc_pkg::OUT_W-1:0]              n_best;
    logic [VERTICES-1:0]                    hit;
    logic [gmc_pkg::CNT_W-1:0]              hit_cnt;
    logic [PW-1:0]                          step_pos;
    logic signed [gmc_pkg::DELTA_W-1:0]     step_delta;
    logic                                   accept;
    logic                                   v_in_range;
    logic [VERTICES:0]                      full_ext;

    assign accept     = start && !busy;
    assign v_in_range = {1'b0, i_vertex_index} < (gmc_pkg::IDX_W + 1)'(VERTICES);
    assign full_ext   = ((VERTICES + 1)'(1) << r_count) - (VERTICES + 1)'(1);

    gmc_build_unit #(
        .VERTICES (VERTICES)
    ) u_build (
        .i_row     (r_adj[r_av[r_pos][IW-1:0]]),
        .i_av      (r_av),
        .i_pos     (r_pos),
        .i_count   (r_count),
        .o_hit     (hit),
        .o_hit_cnt (hit_cnt)
    );

    gmc_delta_unit #(
        .VERTICES (VERTICES)
    ) u_delta (
        .i_subset (r_subset),
        .i_side   (r_side),
        .i_full   (r_full),
        .i_nb     (r_local[step_pos]),
        .o_pos    (step_pos),
        .o_delta  (step_delta)
    );

    assign n_cut  = r_cut + {{(gmc_pkg::CUT_W - gmc_pkg::DELTA_W){r_delta[gmc_pkg::DELTA_W-1]}},
                             r_delta};
    assign n_best = (r_dvalid && (n_cut > $signed({1'b0, r_best})))
                  ? n_cut[gmc_pkg::OUT_W-1:0] : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_dvalid <= 1'b0;
            r_valid  <= 1'b0;
            for (int v = 0; v < VERTICES; v++) begin
                r_adj[v] <= '0;
            end
        end else begin
            r_valid  <= 1'b0;
            r_dvalid <= (r_state == ST_SEARCH);
            if (r_dvalid) begin
                r_cut  <= n_cut;
                r_best <= n_best;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (gmc_pkg::t_func'(i_func))
                            gmc_pkg::FUNC_ROW: begin
                                if (v_in_range) begin
                                    r_adj[i_vertex_index[IW-1:0]] <= i_row_bits;
                                end
                            end
                            gmc_pkg::FUNC_APPEND: begin
                                if (v_in_range && (r_count < CW'(VERTICES))) begin
                                    r_av[r_count[PW-1:0]] <= i_vertex_index;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            gmc_pkg::FUNC_RUN: begin
                                r_edges <= '0;
                                r_best  <= '0;
                                r_cut   <= '0;
                                r_side  <= '0;
                                r_pos   <= '0;
                                r_full  <= full_ext[VERTICES-1:0];
                                for (int v = 0; v < VERTICES; v++) begin
                                    r_local[v] <= '0;
                                end
                                r_state <= (r_count == '0) ? ST_DRAIN : ST_BUILD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_BUILD: begin
                    for (int j = 0; j < VERTICES; j++) begin
                        if (hit[j]) begin
                            r_local[j][r_pos] <= 1'b1;
                        end
                    end
                    r_local[r_pos] <= r_local[r_pos] | hit;
                    r_edges <= r_edges + gmc_pkg::OUT_W'(hit_cnt);
                    r_pos   <= r_pos + PW'(1);
                    if ((CW'(r_pos) + CW'(1)) == r_count) begin
                        r_subset <= VERTICES'(1);
                        r_state  <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    r_delta <= step_delta;
                    r_side  <= r_side ^ (VERTICES'(1) << step_pos);
                    if (r_subset == r_full) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_subset <= r_subset + VERTICES'(1);
                    end
                end
                ST_DRAIN: begin
                    r_valid      <= 1'b1;
                    r_max_cut    <= n_best;
                    r_edge_count <= r_edges;
                    r_deficiency <= r_edges - n_best;
                    r_count      <= '0;
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_max_cut    = r_max_cut;
    assign o_edge_count = r_edge_count;
    assign o_deficiency = r_deficiency;

endmodule

### design/gmc_checker.sv
// Port-level checker for graph_max_cut_gray_search, attached by bind.
// Depends on gmc_pkg and graph_max_cut_gray_search_macros.svh.
`timescale 1ns / 1ps
`include "graph_max_cut_gray_search_macros.svh"

module gmc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic                            o_valid,
    input  logic [gmc_pkg::OUT_W-1:0]       o_max_cut,
    input  logic [gmc_pkg::OUT_W-1:0]       o_edge_count,
    input  logic [gmc_pkg::OUT_W-1:0]       o_deficiency
);

    `GMC_ASSERT_NXT(a_run_goes_busy, i_clk, i_rst_n, start && !busy && (i_func == gmc_pkg::FUNC_RUN), busy)
    `GMC_ASSERT_IMP(a_result_ends_run, i_clk, i_rst_n, $past(i_rst_n) && o_valid, $past(busy) && !busy)
    `GMC_ASSERT_IMP(a_run_end_gives_result, i_clk, i_rst_n, $past(i_rst_n) && $fell(busy), o_valid)
    `GMC_ASSERT_IMP(a_result_consistent, i_clk, i_rst_n, o_valid, (o_max_cut <= o_edge_count) && (o_deficiency == gmc_pkg::OUT_W'(o_edge_count - o_max_cut)))

endmodule

bind graph_max_cut_gray_search gmc_checker u_gmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .o_valid      (o_valid),
    .o_max_cut    (o_max_cut),
    .o_edge_count (o_edge_count),
    .o_deficiency (o_deficiency)
);

### tb/testbench.sv
// Self-checking testbench for graph_max_cut_gray_search: drives row writes,
// vertex appends and search runs, and checks each run against its own max-cut model.
// Depends on gmc_pkg and the graph_max_cut_gray_search RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int VERTICES = 15;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1480;
    localparam int TOTAL_ITEMS = 1600;

    typedef struct packed {
        logic [gmc_pkg::OUT_W-1:0] max_cut;
        logic [gmc_pkg::OUT_W-1:0] edge_count;
        logic [gmc_pkg::OUT_W-1:0] deficiency;
    } t_cut_result;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_func;
    logic [gmc_pkg::IDX_W-1:0] i_vertex_index;
    logic [gmc_pkg::ROW_W-1:0] i_row_bits;
    logic o_valid;
    logic [gmc_pkg::OUT_W-1:0] o_max_cut;
    logic [gmc_pkg::OUT_W-1:0] o_edge_count;
    logic [gmc_pkg::OUT_W-1:0] o_deficiency;

    logic [gmc_pkg::ROW_W-1:0] graph_rows [VERTICES];
    logic [gmc_pkg::IDX_W-1:0] listed_vertices [VERTICES];
    int listed_count;
    t_cut_result cut_results_due [$];
    int accepted_items;
    int mismatch_count;
    bit gaps_on;

    graph_max_cut_gray_search #(
        .VERTICES(VERTICES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_vertex_index(i_vertex_index),
        .i_row_bits(i_row_bits),
        .o_valid(o_valid),
        .o_max_cut(o_max_cut),
        .o_edge_count(o_edge_count),
        .o_deficiency(o_deficiency)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #30_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_cut_result best_bipartition();
        logic [gmc_pkg::ROW_W-1:0] nbr [VERTICES];
        logic [gmc_pkg::ROW_W-1:0] side;
        logic [gmc_pkg::ROW_W-1:0] full;
        logic [gmc_pkg::ROW_W-1:0] same;
        int k;
        int edges;
        int cut;
        int best;
        int p;
        t_cut_result res;
        k = listed_count;
        edges = 0;
        cut = 0;
        best = 0;
        side = '0;
        for (int i = 0; i < VERTICES; i++) begin
            nbr[i] = '0;
        end
        for (int i = 0; i < k; i++) begin
            for (int j = i + 1; j < k; j++) begin
                if (graph_rows[listed_vertices[i]][listed_vertices[j]]) begin
                    nbr[i][j] = 1'b1;
                    nbr[j][i] = 1'b1;
                    edges++;
                end
            end
        end
        full = gmc_pkg::ROW_W'((1 << k) - 1);
        for (int s = 1; s < (1 << k); s++) begin
            p = 0;
            while (s[p] == 1'b0) p++;
            same = side[p] ? side : (~side & full);
            cut += $countones(nbr[p] & same) - $countones(nbr[p] & ~same & full);
            side[p] = ~side[p];
            if (cut > best) begin
                best = cut;
            end
        end
        res.max_cut = gmc_pkg::OUT_W'(best);
        res.edge_count = gmc_pkg::OUT_W'(edges);
        res.deficiency = gmc_pkg::OUT_W'(edges - best);
        return res;
    endfunction

    function automatic void record_request(input logic [1:0] func,
                                           input logic [gmc_pkg::IDX_W-1:0] vertex,
                                           input logic [gmc_pkg::ROW_W-1:0] row);
        case (func)
            gmc_pkg::FUNC_ROW: begin
                if (vertex < VERTICES) begin
                    graph_rows[vertex] = row;
                end
            end
            gmc_pkg::FUNC_APPEND: begin
                if (vertex < VERTICES && listed_count < VERTICES) begin
                    listed_vertices[listed_count] = vertex;
                    listed_count++;
                end
            end
            gmc_pkg::FUNC_RUN: begin
                cut_results_due.push_back(best_bipartition());
                listed_count = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [gmc_pkg::ROW_W-1:0] random_row();
        logic [gmc_pkg::ROW_W-1:0] r;
        r = gmc_pkg::ROW_W'($urandom);
        case ($urandom_range(0, 3))
            0: r = r & gmc_pkg::ROW_W'($urandom);
            1: r = r | gmc_pkg::ROW_W'($urandom);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [1:0] func,
                                input logic [gmc_pkg::IDX_W-1:0] vertex,
                                input logic [gmc_pkg::ROW_W-1:0] row);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_vertex_index <= vertex;
        i_row_bits <= row;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        accepted_items++;
        record_request(func, vertex, row);
    endtask

    always @(posedge i_clk) begin : check_results
        t_cut_result due;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (cut_results_due.size() == 0) begin
                report_mismatch("result with no run pending");
            end else begin
                due = cut_results_due.pop_front();
                if (o_max_cut !== due.max_cut)
                    report_mismatch($sformatf("max_cut %0d, want %0d", o_max_cut, due.max_cut));
                if (o_edge_count !== due.edge_count)
                    report_mismatch($sformatf("edge_count %0d, want %0d",
                                              o_edge_count, due.edge_count));
                if (o_deficiency !== due.deficiency)
                    report_mismatch($sformatf("deficiency %0d, want %0d",
                                              o_deficiency, due.deficiency));
            end
        end
    end

    task automatic graph_sequence(input int size, input bit closed);
        int appends;
        repeat ($urandom_range(0, 5)) begin
            send_request(gmc_pkg::FUNC_ROW, gmc_pkg::IDX_W'($urandom_range(0, 15)),
                         random_row());
        end
        appends = size - listed_count;
        repeat (appends > 0 ? appends : 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request($urandom_range(0, 1) ? FUNC_UNUSED : gmc_pkg::FUNC_ROW,
                             gmc_pkg::IDX_W'($urandom_range(0, 15)), random_row());
            end
            send_request(gmc_pkg::FUNC_APPEND, gmc_pkg::IDX_W'($urandom_range(0, 14)),
                         random_row());
        end
        if (closed) begin
            send_request(gmc_pkg::FUNC_RUN, gmc_pkg::IDX_W'($urandom), random_row());
        end
    endtask

    task automatic noise_burst();
        logic [1:0] func;
        repeat ($urandom_range(1, 6)) begin
            func = 2'($urandom_range(0, 3));
            if (func == gmc_pkg::FUNC_APPEND && listed_count >= 7) begin
                func = FUNC_UNUSED;
            end
            send_request(func, gmc_pkg::IDX_W'($urandom_range(0, 15)), random_row());
        end
    endtask

    task automatic test_empty_list();
        send_request(gmc_pkg::FUNC_RUN, '0, '0);
    endtask

    task automatic test_full_repeated_list();
        send_request(gmc_pkg::FUNC_ROW, 4'd14, 15'h7FFF);
        repeat (VERTICES + 1) send_request(gmc_pkg::FUNC_APPEND, 4'd14, '0);
        send_request(gmc_pkg::FUNC_RUN, 4'd15, 15'h7FFF);
    endtask

    task automatic test_ignored_requests();
        send_request(FUNC_UNUSED, 4'd3, 15'h7FFF);
        send_request(gmc_pkg::FUNC_ROW, 4'd15, 15'h7FFF);
        send_request(gmc_pkg::FUNC_APPEND, 4'd15, '0);
        send_request(gmc_pkg::FUNC_ROW, 4'd0, 15'h4000);
        send_request(gmc_pkg::FUNC_APPEND, 4'd0, '0);
        send_request(gmc_pkg::FUNC_APPEND, 4'd14, '0);
        send_request(gmc_pkg::FUNC_APPEND, 4'd0, '0);
        send_request(gmc_pkg::FUNC_RUN, 4'd0, '0);
    endtask

    task automatic test_random_graphs();
        int big_left;
        int size;
        big_left = 3;
        while (accepted_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                gaps_on = !gaps_on;
            end
            if ($urandom_range(0, 9) < 2) begin
                noise_burst();
            end else begin
                if (big_left > 0 && $urandom_range(0, 49) == 0) begin
                    size = $urandom_range(11, 18);
                    big_left--;
                end else begin
                    size = $urandom_range(0, 7);
                end
                graph_sequence(size, $urandom_range(0, 9) != 0);
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        while (accepted_items < TOTAL_ITEMS) begin
            graph_sequence($urandom_range(0, 6), 1'b1);
        end
        if (listed_count != 0) begin
            send_request(gmc_pkg::FUNC_RUN, '0, '0);
        end
    endtask

    task automatic finish_run();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (cut_results_due.size() != 0 && waited < 40000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (cut_results_due.size() != 0) begin
            report_mismatch("runs left without a result");
        end
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = gmc_pkg::FUNC_ROW;
        i_vertex_index = '0;
        i_row_bits = '0;
        for (int i = 0; i < VERTICES; i++) begin
            graph_rows[i] = '0;
            listed_vertices[i] = '0;
        end
        listed_count = 0;
        accepted_items = 0;
        mismatch_count = 0;
        gaps_on = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_full_repeated_list();
        test_ignored_requests();
        test_random_graphs();
        test_back_to_back();
        finish_run();
    end

endmodule
